// File: rtl/core/mbd_pkg.sv
// Shared types and constants for the mipmap 2x2 box downsampler.
// Used by mbd_lane and mipmap_box_downsample_core; no dependencies.
package mbd_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned MODE_W        = 3;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned PSUM_W        = 10;
  localparam int unsigned NUM_CHAN      = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_NEAREST = 3'd0,
    MODE_AVERAGE = 3'd1,
    MODE_MIX13   = 3'd2,
    MODE_MIX22   = 3'd3,
    MODE_MIX31   = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] pix_alpha;
    logic [CHAN_W-1:0] pix_blue;
    logic [CHAN_W-1:0] pix_green;
    logic [CHAN_W-1:0] pix_red;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              row_end;
    logic              image_end;
  } res_t;

endpackage

// File: rtl/core/mbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module mbd_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mbd_lane.sv
// One channel lane: completes the 2x2 sum, averages, and by mode gives the average, the top-left or a blend of the two.
// Depends on mbd_pkg.
module mbd_lane
  import mbd_pkg::*;
(
  input  logic [PSUM_W-1:0] pair_sum_i,
  input  logic [CHAN_W-1:0] top_left_i,
  input  logic [CHAN_W-1:0] left_i,
  input  logic [CHAN_W-1:0] right_i,
  input  logic [MODE_W-1:0] mode_i,
  output logic [CHAN_W-1:0] result_o
);

  logic [PSUM_W-1:0]   sum;
  logic [CHAN_W-1:0]   avg;
  logic [CHAN_W+1:0]   p_x;
  logic [CHAN_W+1:0]   a_x;
  logic [CHAN_W+1:0]   acc;

  always_comb begin
    // top pair sum at most 510, bottom pair at most 510: fits in ten bits
    sum = pair_sum_i + PSUM_W'(left_i) + PSUM_W'(right_i);
    avg = sum[PSUM_W-1:2];
    p_x = (CHAN_W+2)'(top_left_i);
    a_x = (CHAN_W+2)'(avg);
    acc = '0;
    result_o = avg;
    case (mode_i)
      MODE_NEAREST: result_o = top_left_i;
      MODE_MIX13: begin
        acc      = p_x + a_x + (a_x << 1);
        result_o = acc[CHAN_W+1:2];
      end
      MODE_MIX22: begin
        acc      = p_x + a_x;
        result_o = acc[CHAN_W:1];
      end
      MODE_MIX31: begin
        acc      = p_x + (p_x << 1) + a_x;
        result_o = acc[CHAN_W+1:2];
      end
      default: result_o = avg;
    endcase
  end

endmodule

// File: rtl/core/mipmap_box_downsample_core.sv
// Throughput: one source pixel per clock unless stalled; one result per 2x2 block, from
// the line store's single write port and single registered read port, which each pixel
// uses at most once. Each bottom-right pixel loads the result stage, then out_res_q.
// Reset: counters and held pixel clear, width/height 4096, mode average; the line store
// is not cleared and needs no pass, as it is always written by the even row first.
// Depends on mbd_pkg, mbd_ram and mbd_lane.
module mipmap_box_downsample_core
  import mbd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pix_t                 in_pix_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output res_t                 out_res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CW     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned XW     = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int unsigned DEPTH  = MAX_WIDTH / 2;
  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ENT_W  = NUM_CHAN * (PSUM_W + CHAN_W);
  localparam int unsigned PS_W   = NUM_CHAN * PSUM_W;

  // configuration
  logic [CFG_W-1:0]  width_q, width_d;
  logic [CFG_W-1:0]  height_q, height_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              geo_wr;

  // position and held pixel
  logic [CW-1:0]     col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [31:0]       held_q, held_d;

  // result stage and output register
  logic              s1_valid_q, s1_valid_d;
  logic [31:0]       s1_left_q, s1_right_q;
  logic              s1_re_q, s1_ie_q;
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q;

  logic [XW-1:0]     width_x, eff_w;
  logic [CFG_W-1:0]  eff_h;
  logic              accept, col_last, row_last, row_end, img_end;
  logic              ram_we, ram_re, s1_go;
  logic [31:0]       px;
  logic [PS_W-1:0]   pair_sums;
  logic [SLOT_W-1:0] slot;
  logic [ENT_W-1:0]  ram_rdata;
  logic [CHAN_W-1:0] lane_res [NUM_CHAN];

  assign px      = in_pix_i;
  assign width_x = XW'(width_q);
  assign eff_w   = (width_x == '0) ? XW'(1) :
                   (width_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : width_x;
  assign eff_h   = (height_q == '0) ? CFG_W'(1) :
                   (height_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_q;

  assign s1_go      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign accept     = in_valid_i && !in_stall_o;

  assign col_last = (XW'(col_q) + XW'(1)) >= eff_w;
  assign row_last = (CFG_W'(row_q) + CFG_W'(1)) >= eff_h;
  assign row_end  = (XW'(col_q) + XW'(2)) >= eff_w;
  assign img_end  = row_end && ((CFG_W'(row_q) + CFG_W'(2)) >= eff_h);

  assign slot   = SLOT_W'(col_q >> 1);
  assign ram_we = accept && col_q[0] && !row_q[0];
  assign ram_re = accept && col_q[0] && row_q[0];

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_pair
    assign pair_sums[k*PSUM_W +: PSUM_W] = PSUM_W'(held_q[k*CHAN_W +: CHAN_W])
                                         + PSUM_W'(px[k*CHAN_W +: CHAN_W]);
  end

  mbd_ram #(
    .DATA_W (ENT_W),
    .DEPTH  (DEPTH),
    .ADDR_W (SLOT_W)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i ({held_q, pair_sums}),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // configuration writes; geometry writes restart the frame
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    geo_wr   = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH: begin
          width_d = cfg_data_i;
          geo_wr  = 1'b1;
        end
        REG_HEIGHT: begin
          height_d = cfg_data_i;
          geo_wr   = 1'b1;
        end
        REG_MODE: mode_d = cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    held_d = held_q;
    if (accept) begin
      if (!col_q[0]) begin
        held_d = px;
      end
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    if (geo_wr) begin
      col_d = '0;
      row_d = '0;
    end
  end

  assign s1_valid_d  = ram_re || (s1_valid_q && !s1_go);
  assign out_valid_d = s1_go || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CFG_W'(MAX_WIDTH_DEF);
      height_q    <= CFG_W'(MAX_HEIGHT);
      mode_q      <= MODE_AVERAGE;
      col_q       <= '0;
      row_q       <= '0;
      held_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      mode_q      <= mode_d;
      col_q       <= col_d;
      row_q       <= row_d;
      held_q      <= held_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_left_q  <= held_q;
      s1_right_q <= px;
      s1_re_q    <= row_end;
      s1_ie_q    <= img_end;
    end
  end

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
    mbd_lane u_lane (
      .pair_sum_i (ram_rdata[k*PSUM_W +: PSUM_W]),
      .top_left_i (ram_rdata[PS_W + k*CHAN_W +: CHAN_W]),
      .left_i     (s1_left_q[k*CHAN_W +: CHAN_W]),
      .right_i    (s1_right_q[k*CHAN_W +: CHAN_W]),
      .mode_i     (mode_q),
      .result_o   (lane_res[k])
    );
  end

  // merge the lanes into one result request
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_res_q.out_red   <= lane_res[0];
      out_res_q.out_green <= lane_res[1];
      out_res_q.out_blue  <= lane_res[2];
      out_res_q.out_alpha <= lane_res[3];
      out_res_q.row_end   <= s1_re_q;
      out_res_q.image_end <= s1_ie_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  a_read_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> s1_valid_q)
    else $error("line store read without result stage");

  a_one_port_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("line store read and written by one pixel");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_image_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_res_o.image_end || out_res_o.row_end))
    else $error("image end without row end");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(col_q) < eff_w)
    else $error("column count beyond width");

endmodule

// File: dv/tb.sv
// Self-checking testbench for mipmap_box_downsample_core: streams RGBA source pixels
// under several geometries and filter modes, predicts each 2x2 block result itself.
// Depends on mbd_pkg and the core; nothing else.
module tb;
  import mbd_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned BIG_ITEMS     = 120;
  localparam int unsigned CYCLE_LIMIT   = 1500000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned STORE_DEPTH   = MAX_WIDTH_DEF / 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_UNDEF_TOP = 3'd7;
  localparam logic [CFG_W-1:0]     CFG_ALL_ONES   = 13'h1FFF;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    pix_t                   pix;
    bit                     typed;
    res_t                   want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  pix_t                 in_pix_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  res_t                 out_res_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  mipmap_box_downsample_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_pix_i   (in_pix_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [NUM_CHAN*PSUM_W-1:0] pair_sums [STORE_DEPTH];
  pix_t                       top_lefts [STORE_DEPTH];
  pix_t                       held_pixel;
  int unsigned                col_pos;
  int unsigned                row_pos;
  logic [CFG_W-1:0]           cfg_width;
  logic [CFG_W-1:0]           cfg_height;
  logic [MODE_W-1:0]          cfg_mode;

  res_t        expected_pixels [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          steady;
  // toggled by the sender to ask the sink for a long hold-off
  bit          hold_off_req;

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [CHAN_W-1:0] mix_channel(int unsigned p, int unsigned a);
    case (cfg_mode)
      MODE_NEAREST: return CHAN_W'(p);
      MODE_MIX13:   return CHAN_W'((p + 3 * a) >> 2);
      MODE_MIX22:   return CHAN_W'((p + a) >> 1);
      MODE_MIX31:   return CHAN_W'((3 * p + a) >> 2);
      default:      return CHAN_W'(a);
    endcase
  endfunction

  task automatic downsample_step(input pix_t px, output bit made, output res_t res);
    int unsigned       w;
    int unsigned       h;
    int unsigned       slot;
    int unsigned       sum;
    logic [CHAN_W-1:0] outs [NUM_CHAN];
    w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    slot = col_pos >> 1;
    made = 1'b0;
    res = '0;
    if (col_pos % 2 == 0) begin
      held_pixel = px;
    end else if (row_pos % 2 == 0) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        pair_sums[slot][k*PSUM_W +: PSUM_W] =
          held_pixel[k*CHAN_W +: CHAN_W] + px[k*CHAN_W +: CHAN_W];
      end
      top_lefts[slot] = held_pixel;
    end else begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        sum = pair_sums[slot][k*PSUM_W +: PSUM_W] + held_pixel[k*CHAN_W +: CHAN_W]
            + px[k*CHAN_W +: CHAN_W];
        outs[k] = mix_channel(top_lefts[slot][k*CHAN_W +: CHAN_W], (sum >> 2) & 8'hFF);
      end
      res.out_red   = outs[0];
      res.out_green = outs[1];
      res.out_blue  = outs[2];
      res.out_alpha = outs[3];
      res.row_end   = (col_pos + 2 >= w);
      res.image_end = res.row_end && (row_pos + 2 >= h);
      made = 1'b1;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_t rgba(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
    pix_t p;
    p.pix_red   = r;
    p.pix_green = g;
    p.pix_blue  = b;
    p.pix_alpha = a;
    return p;
  endfunction

  function automatic res_t res_of(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                  logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a,
                                  logic re, logic ie);
    res_t o;
    o.out_red   = r;
    o.out_green = g;
    o.out_blue  = b;
    o.out_alpha = a;
    o.row_end   = re;
    o.image_end = ie;
    return o;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: data, pix: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t pix_row(pix_t px, bit typed = 1'b0, res_t want = '0);
    stim_row_t row;
    row = '{kind: ROW_PIX, idx: '0, data: '0, pix: px, typed: typed, want: want};
    return row;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        cfg_width = val;
        col_pos = 0;
        row_pos = 0;
      end
      REG_HEIGHT: begin
        cfg_height = val;
        col_pos = 0;
        row_pos = 0;
      end
      REG_MODE: cfg_mode = val[MODE_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // valid stays high after acceptance; only a gap or a drain lowers it
  task automatic send_pixel(input pix_t px, input bit typed, input res_t want);
    int unsigned gap;
    bit          made;
    res_t        res;
    gap = (steady || $urandom_range(0, 99) < 65) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pix_i   <= px;
    do @(posedge clk_i); while (in_stall_o);
    downsample_step(px, made, res);
    if (made) expected_pixels.push_back(typed ? want : res);
  endtask

  // even-row requests produce nothing, so allow the pipe to settle after the last result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_pixel(input res_t got);
    res_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected result %h", got);
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    if (got.out_red !== want.out_red) begin
      $error("out_red: expected %0d, got %0d", want.out_red, got.out_red);
      mismatches++;
    end
    if (got.out_green !== want.out_green) begin
      $error("out_green: expected %0d, got %0d", want.out_green, got.out_green);
      mismatches++;
    end
    if (got.out_blue !== want.out_blue) begin
      $error("out_blue: expected %0d, got %0d", want.out_blue, got.out_blue);
      mismatches++;
    end
    if (got.out_alpha !== want.out_alpha) begin
      $error("out_alpha: expected %0d, got %0d", want.out_alpha, got.out_alpha);
      mismatches++;
    end
    if (got.row_end !== want.row_end) begin
      $error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
      mismatches++;
    end
    if (got.image_end !== want.image_end) begin
      $error("image_end: expected %0d, got %0d", want.image_end, got.image_end);
      mismatches++;
    end
  endtask

  initial begin : sink
    int unsigned stall_left;
    bit          hold_seen;
    stall_left  = 0;
    hold_seen   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_pixel(out_res_o);
      if (hold_off_req != hold_seen) begin
        hold_seen  = hold_off_req;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   directed [$];
    int unsigned small_items;
    int unsigned phase;
    int unsigned n;
    int unsigned frame;
    bit          big;
    pix_t        px;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_pix_i     = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_WIDTH;
    cfg_data_i   = '0;
    steady       = 1'b0;
    held_pixel   = '0;
    col_pos      = 0;
    row_pos      = 0;
    cfg_width    = CFG_W'(MAX_WIDTH_DEF);
    cfg_height   = CFG_W'(MAX_HEIGHT);
    cfg_mode     = MODE_AVERAGE;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // mode left at its reset value (average) for the first frame
    directed = '{
      cfg_row(REG_WIDTH, 13'd3), cfg_row(REG_HEIGHT, 13'd2),
      // odd width: third column of each row is dropped
      pix_row(rgba(255, 0, 255, 0)), pix_row(rgba(255, 0, 255, 0)), pix_row(rgba(9, 9, 9, 9)),
      pix_row(rgba(255, 0, 255, 0)),
      pix_row(rgba(255, 0, 255, 0), 1'b1, res_of(255, 0, 255, 0, 1'b1, 1'b1)),
      pix_row(rgba(1, 2, 3, 4)),
      cfg_row(REG_WIDTH, 13'd2), cfg_row(REG_MODE, CFG_W'(MODE_NEAREST)),
      pix_row(rgba(0, 255, 0, 255)), pix_row(rgba(17, 34, 51, 68)),
      pix_row(rgba(200, 100, 50, 25)),
      pix_row(rgba(255, 255, 255, 255), 1'b1, res_of(0, 255, 0, 255, 1'b1, 1'b1)),
      cfg_row(REG_MODE, CFG_W'(MODE_MIX13)),
      pix_row(rgba(10, 250, 0, 255)), pix_row(rgba(200, 3, 255, 0)),
      pix_row(rgba(77, 128, 255, 1)), pix_row(rgba(255, 255, 254, 0)),
      cfg_row(REG_MODE, CFG_W'(MODE_MIX22)),
      pix_row(rgba(255, 0, 7, 128)), pix_row(rgba(1, 255, 9, 127)),
      pix_row(rgba(0, 254, 200, 3)), pix_row(rgba(3, 253, 100, 250)),
      cfg_row(REG_MODE, CFG_W'(MODE_MIX31)),
      pix_row(rgba(99, 1, 255, 60)), pix_row(rgba(255, 0, 0, 61)),
      pix_row(rgba(254, 2, 128, 62)), pix_row(rgba(0, 255, 64, 63)),
      // undefined mode falls back to the average
      cfg_row(REG_MODE, CFG_W'(MODE_UNDEF_TOP)),
      pix_row(rgba(5, 250, 31, 200)), pix_row(rgba(6, 251, 32, 201)),
      pix_row(rgba(7, 252, 33, 202)), pix_row(rgba(8, 253, 35, 255))
    };

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_pixel(directed[i].pix, directed[i].typed, directed[i].want);
      end
    end

    small_items = 0;
    phase = 0;
    while (small_items < RANDOM_ITEMS || phase <= 9) begin
      wait_drained();
      big = (phase == 4) || (phase == 9);
      steady = ($urandom_range(0, 3) == 0);
      case (phase)
        0: begin
          write_reg(REG_WIDTH, 13'd0);
          write_reg(REG_HEIGHT, 13'd5);
        end
        1: begin
          write_reg(REG_WIDTH, 13'd6);
          write_reg(REG_HEIGHT, 13'd0);
        end
        2: begin
          write_reg(REG_WIDTH, 13'd7);
          write_reg(REG_HEIGHT, 13'd1);
        end
        3: begin
          write_reg(REG_WIDTH, 13'd5);
          write_reg(REG_HEIGHT, 13'd3);
        end
        // widest row, width beyond the line store saturates
        4: begin
          write_reg(REG_WIDTH, CFG_ALL_ONES);
          write_reg(REG_HEIGHT, 13'd2);
        end
        9: begin
          write_reg(REG_WIDTH, 13'd2);
          write_reg(REG_HEIGHT, CFG_ALL_ONES);
          write_reg(REG_SPARE, CFG_ALL_ONES);
        end
        default: begin
          if ($urandom_range(0, 99) < 55) begin
            n = $urandom_range(0, 99);
            write_reg(REG_WIDTH, CFG_W'(n < 8  ? $urandom_range(0, 1) :
                                        n < 85 ? $urandom_range(2, 16) :
                                                 $urandom_range(17, 70)));
          end
          if ($urandom_range(0, 99) < 45) begin
            write_reg(REG_HEIGHT, CFG_W'($urandom_range(0, 99) < 10 ? $urandom_range(0, 1) :
                                                                     $urandom_range(2, 9)));
          end
          if ($urandom_range(0, 99) < 5) write_reg(REG_SPARE, CFG_W'($urandom));
        end
      endcase
      write_reg(REG_MODE, CFG_W'($urandom_range(0, 7)));

      frame = clamp_dim(cfg_width, MAX_WIDTH_DEF) * clamp_dim(cfg_height, MAX_HEIGHT);
      if (big) n = (frame > BIG_ITEMS) ? BIG_ITEMS : frame;
      else n = $urandom_range(1, (2 * frame + 4 > 300) ? 300 : 2 * frame + 4);
      // long receiver hold-off while requests keep coming and results pile up
      if (phase == 9) hold_off_req = !hold_off_req;

      for (int unsigned i = 0; i < n; i++) begin
        case ($urandom_range(0, 19))
          0:       px = '0;
          1:       px = '1;
          default: px = pix_t'($urandom);
        endcase
        send_pixel(px, 1'b0, '0);
        if (!big && $urandom_range(0, 149) == 0) wait_drained();
      end
      small_items += n;
      phase++;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
